[src/gbs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbs_pkg: shared constants for the bearing-to-servo datapath
// Fixed-point widths, CORDIC table and reciprocal constants.
// ----------------------------------------------------------------------------
package gbs_pkg;

    // CORDIC iterations, one pipeline stage each
    localparam int CORDIC_STEPS = 24;

    // datapath widths
    localparam int ROT_W = 34;   // sin/cos CORDIC x, y, z (Q30)
    localparam int VEC_W = 36;   // atan2 CORDIC u, v, z (Q30)
    localparam int ANG_W = 35;   // wrapped angle, degrees * 2^22

    // angle constants, degrees * 2^22
    localparam logic signed [ANG_W-1:0] HALF_TURN    = 35'sd754974720;
    localparam logic signed [ANG_W-1:0] FULL_TURN    = 35'sd1509949440;
    localparam logic signed [ANG_W-1:0] QUARTER_TURN = 35'sd377487360;

    // degrees to Q30 radians: d * 4544 / 1017, reciprocal ceil(4544 * 2^32 / 1017)
    localparam logic [34:0] DEG2RAD_RECIP = 35'd19190099699;
    localparam logic [12:0] DEG2RAD_NUM   = 13'd4544;
    localparam logic [9:0]  DEG2RAD_DEN   = 10'd1017;

    // Q30 radians to degrees * 2^16: z * 1017 / (4096 * 71)
    localparam logic [9:0]  RAD2DEG_NUM  = 10'd1017;
    localparam logic [30:0] DIV71_RECIP  = 31'd1935759909;   // ceil(2^37 / 71)
    localparam logic [6:0]  DIV71        = 7'd71;

    // servo mapping: divide by 180, reciprocal ceil(2^30 / 180)
    localparam logic [22:0] DIV180_RECIP = 23'd5965233;

    localparam logic signed [ROT_W-1:0] CORDIC_GAIN = 34'sh026DD3B6A;
    localparam logic signed [VEC_W-1:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [24:0]      BEARING_LIM = 25'sd11796480;

    // register stages from input beat to output beat
    localparam int PIPE_LAT = 13 + 2 * CORDIC_STEPS;

    // configuration register indexes
    localparam logic [1:0] REG_PULSE_MAX = 2'd0;
    localparam logic [1:0] REG_PULSE_MIN = 2'd1;
    localparam logic [11:0] PULSE_MAX_RST = 12'd2500;
    localparam logic [11:0] PULSE_MIN_RST = 12'd500;

    // arctangent of 2^-i, Q30
    function automatic logic [31:0] atan_q30(input int unsigned idx);
        logic [31:0] val;
        case (idx)
            0:       val = 32'h3243F6A8;
            1:       val = 32'h1DAC6705;
            2:       val = 32'h0FADBAFC;
            3:       val = 32'h07F56EA6;
            4:       val = 32'h03FEAB76;
            5:       val = 32'h01FFD55B;
            6:       val = 32'h00FFFAAA;
            7:       val = 32'h007FFF55;
            8:       val = 32'h003FFFEA;
            9:       val = 32'h001FFFFD;
            10:      val = 32'h000FFFFF;
            11:      val = 32'h0007FFFF;
            12:      val = 32'h0003FFFF;
            13:      val = 32'h0001FFFF;
            14:      val = 32'h0000FFFF;
            15:      val = 32'h00007FFF;
            16:      val = 32'h00003FFF;
            17:      val = 32'h00001FFF;
            18:      val = 32'h00000FFF;
            19:      val = 32'h000007FF;
            20:      val = 32'h000003FF;
            21:      val = 32'h000001FF;
            22:      val = 32'h000000FF;
            23:      val = 32'h0000007F;
            24:      val = 32'h0000003F;
            25:      val = 32'h0000001F;
            26:      val = 32'h0000000F;
            27:      val = 32'h00000008;
            28:      val = 32'h00000004;
            29:      val = 32'h00000002;
            30:      val = 32'h00000001;
            default: val = 32'h00000000;
        endcase
        return val;
    endfunction

endpackage
`default_nettype wire

[src/gps_bearing_to_servo_pulse.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Throughput: one beat per cycle while the output is not stalled; every
// CORDIC iteration has its own pipeline stage. A stall on the output
// holds the whole pipeline. Reset clears the valid chain and loads
// pulse_max = 2500 and pulse_min = 500.
// ----------------------------------------------------------------------------
module gps_bearing_to_servo_pulse
    import gbs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [11:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [29:0] here_lat,
    input  logic signed [30:0] here_lon,
    input  logic signed [29:0] target_lat,
    input  logic signed [30:0] target_lon,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [24:0] bearing,
    output logic [11:0]        servo_pulse,
    output logic               in_front
);

    typedef struct packed {
        logic [28:0] mag;    // |folded angle|, degrees * 2^22
        logic        neg;    // folded angle negative
        logic        flip;   // cosine to be negated
    } angle_t;

    // wrap into (-180, 180] then fold into [-90, 90]
    function automatic angle_t wrap_fold(input logic signed [ANG_W-1:0] d);
        logic signed [ANG_W-1:0] w;
        logic signed [ANG_W-1:0] f;
        angle_t                  res;
        if (d > HALF_TURN + FULL_TURN)
            w = d - FULL_TURN - FULL_TURN;
        else if (d > HALF_TURN)
            w = d - FULL_TURN;
        else if (d <= -HALF_TURN - FULL_TURN)
            w = d + FULL_TURN + FULL_TURN;
        else if (d <= -HALF_TURN)
            w = d + FULL_TURN;
        else
            w = d;
        res.flip = 1'b1;
        if (w > QUARTER_TURN)
            f = HALF_TURN - w;
        else if (w < -QUARTER_TURN)
            f = -HALF_TURN - w;
        else
        begin
            f = w;
            res.flip = 1'b0;
        end
        res.neg = f[ANG_W-1];
        res.mag = f[ANG_W-1] ? 29'(-f) : 29'(f);
        return res;
    endfunction

    logic en;
    logic vld_reg [PIPE_LAT];

    logic [11:0] pulse_max_reg;
    logic [11:0] pulse_min_reg;

    // input stage
    logic signed [29:0] lat1_reg, lat2_reg;
    logic signed [30:0] lon1_reg, lon2_reg;

    // wrap stage
    angle_t a_ang_reg [3];

    // reciprocal multiply stage
    angle_t      b_ang_reg [3];
    logic [31:0] b_qe_reg  [3];

    // correction stage, feeds the sin/cos CORDICs
    logic signed [ROT_W-1:0] c_z_reg    [3];
    logic                    c_flip_reg [3];

    logic signed [ROT_W-1:0] s1, c1, s2, c2, sd, cd;

    // product stages
    logic signed [ROT_W-1:0] p1_m1_reg, p1_m2_reg, p1_m3_reg, p1_cd_reg;
    logic signed [ROT_W-1:0] p2_m1_reg, p2_m2_reg, p2_m4_reg;
    logic signed [VEC_W-1:0] p3_x_reg, p3_y_reg;

    // atan2 setup stage
    logic signed [VEC_W-1:0] v0_u_reg, v0_v_reg, v0_z_reg;
    logic                    v0_zero_reg;

    logic signed [VEC_W-1:0] vz;
    logic                    vzero;

    // degree scaling and servo mapping stages
    logic [43:0]        t1_a_reg;
    logic               t1_neg_reg;
    logic [30:0]        t2_t_reg;
    logic [24:0]        t2_qe_reg;
    logic               t2_neg_reg;
    logic signed [24:0] t3_b_reg;
    logic signed [21:0] t4_p_reg;
    logic signed [24:0] t4_b_reg;
    logic               t4_front_reg;

    logic signed [24:0] bearing_reg;
    logic [11:0]        servo_pulse_reg;
    logic               in_front_reg;

    // pipeline advances unless the output beat is held
    assign en       = !vld_reg[PIPE_LAT-1] || out_ready;
    assign in_ready = en;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_max_reg <= PULSE_MAX_RST;
            pulse_min_reg <= PULSE_MIN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PULSE_MAX: pulse_max_reg <= cfg_data;
                REG_PULSE_MIN: pulse_min_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < PIPE_LAT; k++)
                vld_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k < PIPE_LAT; k++)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    // front end: capture, wrap, degrees to radians
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lat1_reg <= here_lat;
            lon1_reg <= here_lon;
            lat2_reg <= target_lat;
            lon2_reg <= target_lon;

            a_ang_reg[0] <= wrap_fold(ANG_W'(lat1_reg));
            a_ang_reg[1] <= wrap_fold(ANG_W'(lat2_reg));
            a_ang_reg[2] <= wrap_fold(ANG_W'(lon2_reg) - ANG_W'(lon1_reg));
        end
    end

    always_ff @(posedge clk)
    begin
        logic [63:0]        prod;
        logic signed [43:0] rem;
        logic [31:0]        q;
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                // estimate may be one high
                prod = 64'(a_ang_reg[k].mag) * 64'(DEG2RAD_RECIP);
                b_ang_reg[k] <= a_ang_reg[k];
                b_qe_reg[k]  <= prod[63:32];

                rem = $signed(44'(b_ang_reg[k].mag) * 44'(DEG2RAD_NUM))
                    - $signed(44'(b_qe_reg[k]) * 44'(DEG2RAD_DEN));
                q = (rem < 0) ? b_qe_reg[k] - 32'd1 : b_qe_reg[k];
                c_z_reg[k]    <= b_ang_reg[k].neg ? -$signed(ROT_W'(q))
                                                  : $signed(ROT_W'(q));
                c_flip_reg[k] <= b_ang_reg[k].flip;
            end
        end
    end

    gbs_sincos u_sc_lat1 (
        .clk     (clk),
        .en      (en),
        .z_in    (c_z_reg[0]),
        .flip_in (c_flip_reg[0]),
        .sin_out (s1),
        .cos_out (c1)
    );

    gbs_sincos u_sc_lat2 (
        .clk     (clk),
        .en      (en),
        .z_in    (c_z_reg[1]),
        .flip_in (c_flip_reg[1]),
        .sin_out (s2),
        .cos_out (c2)
    );

    gbs_sincos u_sc_dlon (
        .clk     (clk),
        .en      (en),
        .z_in    (c_z_reg[2]),
        .flip_in (c_flip_reg[2]),
        .sin_out (sd),
        .cos_out (cd)
    );

    // spherical terms, Q30 products with floor shift
    always_ff @(posedge clk)
    begin
        logic signed [2*ROT_W-1:0] pr1, pr2, pr3, pr4;
        if (en)
        begin
            pr1 = (2*ROT_W)'(c2) * (2*ROT_W)'(sd);
            pr2 = (2*ROT_W)'(c1) * (2*ROT_W)'(s2);
            pr3 = (2*ROT_W)'(s1) * (2*ROT_W)'(c2);
            p1_m1_reg <= pr1[ROT_W+29:30];
            p1_m2_reg <= pr2[ROT_W+29:30];
            p1_m3_reg <= pr3[ROT_W+29:30];
            p1_cd_reg <= cd;

            pr4 = (2*ROT_W)'(p1_m3_reg) * (2*ROT_W)'(p1_cd_reg);
            p2_m1_reg <= p1_m1_reg;
            p2_m2_reg <= p1_m2_reg;
            p2_m4_reg <= pr4[ROT_W+29:30];

            p3_x_reg <= VEC_W'(p2_m1_reg);
            p3_y_reg <= VEC_W'(p2_m2_reg) - VEC_W'(p2_m4_reg);
        end
    end

    // atan2 setup: zero vector flag, left half-plane flip
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v0_zero_reg <= (p3_y_reg == '0) && (p3_x_reg == '0);
            if (p3_y_reg < 0)
            begin
                v0_z_reg <= (p3_x_reg >= 0) ? PI_Q30 : -PI_Q30;
                v0_u_reg <= -p3_y_reg;
                v0_v_reg <= -p3_x_reg;
            end
            else
            begin
                v0_z_reg <= '0;
                v0_u_reg <= p3_y_reg;
                v0_v_reg <= p3_x_reg;
            end
        end
    end

    gbs_atan2 u_atan2 (
        .clk      (clk),
        .en       (en),
        .u_in     (v0_u_reg),
        .v_in     (v0_v_reg),
        .z_in     (v0_z_reg),
        .zero_in  (v0_zero_reg),
        .z_out    (vz),
        .zero_out (vzero)
    );

    // radians to degrees * 2^16, clamp, servo mapping
    always_ff @(posedge clk)
    begin
        logic signed [VEC_W-1:0] zf;
        logic [33:0]             zmag;
        logic [61:0]             pr71;
        logic signed [33:0]      rem71;
        logic [24:0]             q71;
        logic signed [25:0]      bw;
        logic [24:0]             bmag;
        logic signed [8:0]       w;
        logic signed [12:0]      diff;
        logic [21:0]             pmag;
        logic [44:0]             pr180;
        logic [12:0]             q180;
        logic signed [13:0]      qs;
        logic signed [13:0]      psum;
        if (en)
        begin
            zf   = vzero ? '0 : vz;
            zmag = zf[VEC_W-1] ? 34'(-zf) : 34'(zf);
            t1_a_reg   <= 44'(zmag) * 44'(RAD2DEG_NUM);
            t1_neg_reg <= zf[VEC_W-1];

            // floor(a / 4096) / 71, estimate may be one high
            pr71 = 62'(t1_a_reg[42:12]) * 62'(DIV71_RECIP);
            t2_t_reg   <= t1_a_reg[42:12];
            t2_qe_reg  <= pr71[61:37];
            t2_neg_reg <= t1_neg_reg;

            rem71 = $signed(34'(t2_t_reg)) - $signed(34'(t2_qe_reg) * 34'(DIV71));
            q71   = (rem71 < 0) ? t2_qe_reg - 25'd1 : t2_qe_reg;
            bw    = t2_neg_reg ? -$signed(26'(q71)) : $signed(26'(q71));
            if (bw > 26'(BEARING_LIM))
                t3_b_reg <= BEARING_LIM;
            else if (bw < -26'(BEARING_LIM))
                t3_b_reg <= -BEARING_LIM;
            else
                t3_b_reg <= bw[24:0];

            // whole degrees toward zero, times (min - max)
            bmag = t3_b_reg[24] ? 25'(-t3_b_reg) : 25'(t3_b_reg);
            w    = t3_b_reg[24] ? -$signed({1'b0, bmag[23:16]})
                                : $signed({1'b0, bmag[23:16]});
            diff = $signed({1'b0, pulse_min_reg}) - $signed({1'b0, pulse_max_reg});
            t4_p_reg     <= 22'(w) * 22'(diff);
            t4_b_reg     <= t3_b_reg;
            t4_front_reg <= t3_b_reg > 0;

            // truncating divide by 180, then offset by the travel end
            pmag  = t4_p_reg[21] ? 22'(-t4_p_reg) : 22'(t4_p_reg);
            pr180 = 45'(pmag) * 45'(DIV180_RECIP);
            q180  = pr180[42:30];
            qs    = t4_p_reg[21] ? -$signed({1'b0, q180}) : $signed({1'b0, q180});
            psum  = qs + $signed({2'b00, t4_front_reg ? pulse_max_reg : pulse_min_reg});
            bearing_reg     <= t4_b_reg;
            servo_pulse_reg <= psum[11:0];
            in_front_reg    <= t4_front_reg;
        end
    end

    assign out_valid   = vld_reg[PIPE_LAT-1];
    assign bearing     = bearing_reg;
    assign servo_pulse = servo_pulse_reg;
    assign in_front    = in_front_reg;

endmodule
`default_nettype wire

[src/gbs_sincos.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbs_sincos: pipelined rotation-mode CORDIC
// One iteration per stage; gives sin and cos of a Q30 angle in [-pi/2, pi/2],
// cos negated when the folded-angle flag is set.
// ----------------------------------------------------------------------------
module gbs_sincos
    import gbs_pkg::*;
(
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [ROT_W-1:0] z_in,
    input  logic                    flip_in,
    output logic signed [ROT_W-1:0] sin_out,
    output logic signed [ROT_W-1:0] cos_out
);

    logic signed [ROT_W-1:0] x_reg    [CORDIC_STEPS];
    logic signed [ROT_W-1:0] y_reg    [CORDIC_STEPS];
    logic signed [ROT_W-1:0] z_reg    [CORDIC_STEPS];
    logic                    flip_reg [CORDIC_STEPS];

    genvar i;
    generate
        for (i = 0; i < CORDIC_STEPS; i++)
        begin : g_stage
            localparam logic signed [ROT_W-1:0] ATAN_I = ROT_W'(atan_q30(i));
            logic signed [ROT_W-1:0] x_cur, y_cur, z_cur;
            logic signed [ROT_W-1:0] x_next, y_next, z_next;
            logic                    flip_cur;

            if (i == 0)
            begin : g_first
                assign x_cur    = CORDIC_GAIN;
                assign y_cur    = '0;
                assign z_cur    = z_in;
                assign flip_cur = flip_in;
            end
            else
            begin : g_rest
                assign x_cur    = x_reg[i-1];
                assign y_cur    = y_reg[i-1];
                assign z_cur    = z_reg[i-1];
                assign flip_cur = flip_reg[i-1];
            end

            // rotate towards zero residual angle
            always_comb
            begin
                if (z_cur >= 0)
                begin
                    x_next = x_cur - (y_cur >>> i);
                    y_next = y_cur + (x_cur >>> i);
                    z_next = z_cur - ATAN_I;
                end
                else
                begin
                    x_next = x_cur + (y_cur >>> i);
                    y_next = y_cur - (x_cur >>> i);
                    z_next = z_cur + ATAN_I;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    x_reg[i]    <= x_next;
                    y_reg[i]    <= y_next;
                    z_reg[i]    <= z_next;
                    flip_reg[i] <= flip_cur;
                end
            end
        end
    endgenerate

    assign sin_out = y_reg[CORDIC_STEPS-1];
    assign cos_out = flip_reg[CORDIC_STEPS-1] ? -x_reg[CORDIC_STEPS-1]
                                              : x_reg[CORDIC_STEPS-1];

endmodule
`default_nettype wire

[src/gbs_atan2.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbs_atan2: pipelined vectoring-mode CORDIC
// Drives v to zero one iteration per stage and accumulates the angle in z.
// ----------------------------------------------------------------------------
module gbs_atan2
    import gbs_pkg::*;
(
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [VEC_W-1:0] u_in,
    input  logic signed [VEC_W-1:0] v_in,
    input  logic signed [VEC_W-1:0] z_in,
    input  logic                    zero_in,
    output logic signed [VEC_W-1:0] z_out,
    output logic                    zero_out
);

    logic signed [VEC_W-1:0] u_reg    [CORDIC_STEPS];
    logic signed [VEC_W-1:0] v_reg    [CORDIC_STEPS];
    logic signed [VEC_W-1:0] z_reg    [CORDIC_STEPS];
    logic                    zero_reg [CORDIC_STEPS];

    genvar i;
    generate
        for (i = 0; i < CORDIC_STEPS; i++)
        begin : g_stage
            localparam logic signed [VEC_W-1:0] ATAN_I = VEC_W'(atan_q30(i));
            logic signed [VEC_W-1:0] u_cur, v_cur, z_cur;
            logic signed [VEC_W-1:0] u_next, v_next, z_next;
            logic                    zero_cur;

            if (i == 0)
            begin : g_first
                assign u_cur    = u_in;
                assign v_cur    = v_in;
                assign z_cur    = z_in;
                assign zero_cur = zero_in;
            end
            else
            begin : g_rest
                assign u_cur    = u_reg[i-1];
                assign v_cur    = v_reg[i-1];
                assign z_cur    = z_reg[i-1];
                assign zero_cur = zero_reg[i-1];
            end

            // rotate the vector onto the u axis
            always_comb
            begin
                if (v_cur < 0)
                begin
                    u_next = u_cur - (v_cur >>> i);
                    v_next = v_cur + (u_cur >>> i);
                    z_next = z_cur - ATAN_I;
                end
                else
                begin
                    u_next = u_cur + (v_cur >>> i);
                    v_next = v_cur - (u_cur >>> i);
                    z_next = z_cur + ATAN_I;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    u_reg[i]    <= u_next;
                    v_reg[i]    <= v_next;
                    z_reg[i]    <= z_next;
                    zero_reg[i] <= zero_cur;
                end
            end
        end
    endgenerate

    assign z_out    = z_reg[CORDIC_STEPS-1];
    assign zero_out = zero_reg[CORDIC_STEPS-1];

endmodule
`default_nettype wire
